/* rtl/diffraction_r_factor_top_assert.svh */
// ----------------------------------------------------------------------------
// R-factor engine assertion macros
// Shared clocked assertion forms on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DIFFRACTION_R_FACTOR_TOP_ASSERT_SVH
`define DIFFRACTION_R_FACTOR_TOP_ASSERT_SVH

// property holds at every edge
`define DRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("drf assertion failed");

// consequent holds in the cycle after the antecedent
`define DRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("drf assertion failed");

`endif

/* rtl/drf_pkg.sv */
// ----------------------------------------------------------------------------
// R-factor engine package
// Sizes, codes, shared types and helpers of the R-factor engine.
// ----------------------------------------------------------------------------
package drf_pkg;

  localparam int MaxPoints = 4096;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int FieldW    = 24;
  localparam int SumW      = 64;
  localparam int QuoW      = 32;
  localparam int DevW      = 48;
  localparam int OcW       = 13;
  localparam int LimW      = 16;
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 16;
  localparam int InDataW   = 96;
  localparam int OutDataW  = 96;

  localparam logic [CfgIdxW-1:0] CfgIdxMode  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxLimit = 8'd1;
  localparam logic [LimW-1:0]    LimitReset  = 16'd768;

  typedef enum logic [1:0] {
    ModeWls = 2'd0,
    ModeWcr = 2'd1,
    ModeLs  = 2'd2,
    ModeCr  = 2'd3
  } drf_mode_e;

  typedef struct packed {
    logic              meridional;
    logic [FieldW-1:0] amplitude_error;
    logic [FieldW-1:0] intensity_error;
    logic [FieldW-1:0] calculated;
    logic [FieldW-1:0] observed;
  } drf_point_t;

  typedef struct packed {
    drf_point_t point;
    logic       store;
    logic       last;
  } drf_item_t;

  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

endpackage

/* rtl/drf_front.sv */
// ----------------------------------------------------------------------------
// R-factor engine front end
// Accepts point beats, drops points that carry nothing, queues the rest.
// ----------------------------------------------------------------------------
module drf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [drf_pkg::InDataW-1:0] in_data_i,
  input  logic                        in_user_i,
  input  logic                        in_last_i,
  output logic                        item_valid_o,
  input  logic                        item_ready_i,
  output drf_pkg::drf_item_t          item_o
);

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  drf_pkg::drf_item_t    q_mem [QDepth];
  drf_pkg::drf_item_t    new_item;
  logic [QPtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]      fill_q, fill_d;
  logic                  push, pop;

  always_comb begin
    new_item.point.observed        = in_data_i[23:0];
    new_item.point.calculated      = in_data_i[47:24];
    new_item.point.intensity_error = in_data_i[71:48];
    new_item.point.amplitude_error = in_data_i[95:72];
    new_item.point.meridional      = in_user_i;
    new_item.store                 = in_data_i[71:48] != '0;
    new_item.last                  = in_last_i;
  end

  assign in_ready_o   = fill_q != QCntW'(QDepth);
  assign item_valid_o = fill_q != '0;
  assign item_o       = q_mem[rd_q];
  assign push = in_valid_i && in_ready_o && (new_item.store || new_item.last);
  assign pop  = item_valid_o && item_ready_i;

  always_comb begin
    wr_d   = push ? wr_q + 1'b1 : wr_q;
    rd_d   = pop ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= new_item;
    end
  end

endmodule

/* rtl/drf_sqrt.sv */
// ----------------------------------------------------------------------------
// R-factor engine square root
// Digit-by-digit integer square root of a 32-bit value, one digit a cycle.
// ----------------------------------------------------------------------------
module drf_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] val_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [15:0] root_o
);

  localparam int Steps = 16;
  localparam int StepW = $clog2(Steps);

  logic             busy_q, done_q;
  logic [StepW-1:0] cnt_q;
  logic [31:0]      v_q, v_d, res_q, res_d, bit_q, trial;

  always_comb begin
    trial = res_q + bit_q;
    if (v_q >= trial) begin
      v_d   = v_q - trial;
      res_d = (res_q >> 1) + bit_q;
    end else begin
      v_d   = v_q;
      res_d = res_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= StepW'(Steps - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
      bit_q <= 32'h4000_0000;
    end else if (busy_q) begin
      v_q   <= v_d;
      res_q <= res_d;
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = res_q[15:0];

endmodule

/* rtl/drf_div.sv */
// ----------------------------------------------------------------------------
// R-factor engine divider
// Restoring divider, one quotient bit a cycle: floor(num * 2^fb / den),
// saturated to 32 bits; a zero divisor saturates.
// ----------------------------------------------------------------------------
module drf_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [drf_pkg::SumW-1:0] num_i,
  input  logic [drf_pkg::SumW-1:0] den_i,
  input  logic                     fb24_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [drf_pkg::QuoW-1:0] quo_o
);

  localparam int Steps = drf_pkg::SumW + 24;
  localparam int StepW = $clog2(Steps);

  logic                     busy_q, done_q, ovf_q, zero_q, qbit;
  logic [StepW-1:0]         cnt_q;
  logic [Steps-1:0]         dvd_q;
  logic [drf_pkg::SumW-1:0] rem_q, rem_d, den_q;
  logic [drf_pkg::SumW:0]   trial;
  logic [drf_pkg::QuoW-1:0] quo_q;

  always_comb begin
    trial = {rem_q, dvd_q[Steps-1]};
    qbit  = trial >= {1'b0, den_q};
    rem_d = qbit ? drf_pkg::SumW'(trial - {1'b0, den_q}) : trial[drf_pkg::SumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= StepW'(Steps - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= fb24_i ? {num_i, 24'd0} : {8'd0, num_i, 16'd0};
      rem_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
      den_q  <= den_i;
      zero_q <= den_i == '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
      quo_q <= {quo_q[drf_pkg::QuoW-2:0], qbit};
      ovf_q <= ovf_q | quo_q[drf_pkg::QuoW-1];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = (ovf_q || zero_q) ? {drf_pkg::QuoW{1'b1}} : quo_q;

endmodule

/* rtl/drf_back.sv */
// ----------------------------------------------------------------------------
// R-factor engine back end
// Point store, two-pass sequencer, shared multiplier, scale and R divides.
// ----------------------------------------------------------------------------
`include "diffraction_r_factor_top_assert.svh"

module drf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  drf_pkg::drf_mode_e            mode_i,
  input  logic [drf_pkg::LimW-1:0]      limit_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  drf_pkg::drf_item_t            item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [drf_pkg::QuoW-1:0]      r_off_o,
  output logic [drf_pkg::QuoW-1:0]      r_mer_o,
  output logic [drf_pkg::OcW-1:0]       oc_off_o,
  output logic [drf_pkg::OcW-1:0]       oc_mer_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_LD, S_SQO, S_SQC, S_DVP, S_DVQ,
    S_M1, S_M2, S_M3, S_M4, S_K1, S_K2, S_K3, S_K4,
    S_KDIV, S_KWAIT, S_RDIV, S_RWAIT, S_OUT
  } state_e;

  localparam int SumW = drf_pkg::SumW;
  localparam int QuoW = drf_pkg::QuoW;
  localparam int DevW = drf_pkg::DevW;
  localparam int OcW  = drf_pkg::OcW;
  localparam int CntW = drf_pkg::CntW;

  state_e                   state_q, state_d;
  drf_pkg::drf_point_t      mem [drf_pkg::MaxPoints];
  drf_pkg::drf_point_t      rd_q, pt_q;
  logic [CntW-1:0]          cnt_q, idx_q;
  logic                     pass_q, set_q, outl_q;
  logic [SumW-1:0]          norm_q [2];
  logic [SumW-1:0]          num_q [2];
  logic [SumW-1:0]          den_q [2];
  logic [SumW-1:0]          res_q [2];
  logic [QuoW-1:0]          k_q [2];
  logic [QuoW-1:0]          r_q [2];
  logic [OcW-1:0]           oc_q [2];
  logic [15:0]              fo_q, fc_q;
  logic [QuoW-1:0]          p_q, q_q, mul_a, mul_b, b0, b1, b2;
  logic [SumW-1:0]          prod_q, term;
  logic [DevW-1:0]          dev_q, kq, p_ext;
  logic                     weighted, odd_mode, sq_mode, s;
  logic                     mem_we, pop;
  logic                     sq_start, sq_busy, sq_done;
  logic [31:0]              sq_val;
  logic [15:0]              sq_root;
  logic                     div_start, div_busy, div_done, div_fb24;
  logic [SumW-1:0]          div_num, div_den;
  logic [QuoW-1:0]          div_quo;
  logic                     k_done, r_done, outl_d;
  logic [QuoW-1:0]          k_val, r_val;
  logic [drf_pkg::FieldW-1:0] err;

  assign weighted = mode_i == drf_pkg::ModeWls || mode_i == drf_pkg::ModeWcr;
  assign odd_mode = mode_i == drf_pkg::ModeWcr || mode_i == drf_pkg::ModeCr;
  assign sq_mode  = mode_i == drf_pkg::ModeWls || mode_i == drf_pkg::ModeLs;
  assign s        = pt_q.meridional;
  assign err      = mode_i == drf_pkg::ModeLs ? pt_q.intensity_error : pt_q.amplitude_error;

  function automatic logic [QuoW-1:0] to_q24(logic [SumW-1:0] x, drf_pkg::drf_mode_e m);
    logic [QuoW-1:0] y;
    unique case (m)
      drf_pkg::ModeWls: y = (x[63:40] != '0) ? '1 : x[39:8];
      drf_pkg::ModeCr:  y = (x[63:16] != '0) ? '1 : {x[15:0], 16'd0};
      default:          y = (x[63:24] != '0) ? '1 : {x[23:0], 8'd0};
    endcase
    return y;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (item_valid_i && item_i.last) state_d = S_RD;
      S_RD:    if (idx_q == cnt_q) state_d = pass_q ? S_RDIV : S_KDIV;
               else state_d = S_LD;
      S_LD:    state_d = S_SQO;
      S_SQO:   if (sq_done) state_d = S_SQC;
      S_SQC:   if (sq_done) state_d = weighted ? S_DVP : (pass_q ? S_K1 : S_M1);
      S_DVP:   if (div_done) state_d = S_DVQ;
      S_DVQ:   if (div_done) state_d = pass_q ? S_K1 : S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_M3;
      S_M3:    state_d = S_M4;
      S_M4:    state_d = S_RD;
      S_K1:    state_d = S_K2;
      S_K2:    state_d = S_K3;
      S_K3:    state_d = S_K4;
      S_K4:    state_d = S_RD;
      S_KDIV:  if (den_q[set_q] != '0) state_d = S_KWAIT;
               else if (set_q) state_d = S_RD;
      S_KWAIT: if (div_done) state_d = set_q ? S_RD : S_KDIV;
      S_RDIV:  if (norm_q[set_q] != '0) state_d = S_RWAIT;
               else if (set_q) state_d = S_OUT;
      S_RWAIT: if (div_done) state_d = set_q ? S_OUT : S_RDIV;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and unit control
  always_comb begin
    item_ready_o = state_q == S_IDLE;
    out_valid_o  = state_q == S_OUT;
    pop          = item_ready_o && item_valid_i;
    mem_we       = pop && item_i.store && (cnt_q < CntW'(drf_pkg::MaxPoints));
    sq_start     = (state_q == S_LD) || (state_q == S_SQO && sq_done);
    sq_val       = (state_q == S_LD) ? {rd_q.observed, 8'd0} : {pt_q.calculated, 8'd0};
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    div_fb24     = 1'b0;
    unique case (state_q)
      S_SQC: begin
        div_start = sq_done && weighted;
        div_num   = (mode_i == drf_pkg::ModeWls) ? SumW'(pt_q.observed) : SumW'(fo_q);
        div_den   = (mode_i == drf_pkg::ModeWls) ? SumW'(pt_q.intensity_error)
                                                 : SumW'(pt_q.amplitude_error);
      end
      S_DVP: begin
        div_start = div_done;
        div_num   = (mode_i == drf_pkg::ModeWls) ? SumW'(pt_q.calculated) : SumW'(fc_q);
        div_den   = (mode_i == drf_pkg::ModeWls) ? SumW'(pt_q.intensity_error)
                                                 : SumW'(pt_q.amplitude_error);
      end
      S_KDIV: begin
        div_start = den_q[set_q] != '0;
        div_num   = num_q[set_q];
        div_den   = den_q[set_q];
      end
      S_RDIV: begin
        div_start = norm_q[set_q] != '0;
        div_num   = res_q[set_q];
        div_den   = norm_q[set_q];
        div_fb24  = 1'b1;
      end
      default: ;
    endcase
  end

  // multiplier operands
  always_comb begin
    b0 = sq_mode ? p_q : QuoW'(1);
    b1 = (mode_i == drf_pkg::ModeWls) ? q_q :
         (mode_i == drf_pkg::ModeWcr) ? QuoW'(fc_q) : QuoW'(1);
    b2 = (mode_i == drf_pkg::ModeWls) ? q_q :
         (mode_i == drf_pkg::ModeWcr) ? QuoW'(fc_q) : QuoW'(1);
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_M1: begin mul_a = p_q; mul_b = b0; end
      S_M2: begin mul_a = p_q; mul_b = b1; end
      S_M3: begin mul_a = q_q; mul_b = b2; end
      S_K1: begin mul_a = k_q[s]; mul_b = q_q; end
      S_K2: begin mul_a = QuoW'(limit_i); mul_b = QuoW'(err); end
      S_K3: begin mul_a = dev_q[QuoW-1:0]; mul_b = dev_q[QuoW-1:0]; end
      default: ;
    endcase
  end

  always_comb begin
    kq     = prod_q[SumW-1:16];
    p_ext  = DevW'(p_q);
    outl_d = weighted ? (dev_q > DevW'({limit_i, 8'd0}))
                      : ({dev_q, 8'd0} > (DevW + 8)'(prod_q));
    term   = odd_mode ? SumW'(dev_q)
                      : ((dev_q[DevW-1:QuoW] != '0) ? {SumW{1'b1}} : prod_q);
    k_done = (state_q == S_KDIV && den_q[set_q] == '0) || (state_q == S_KWAIT && div_done);
    k_val  = (state_q == S_KDIV) ? '0 : div_quo;
    r_done = (state_q == S_RDIV && norm_q[set_q] == '0) || (state_q == S_RWAIT && div_done);
    r_val  = (state_q == S_RDIV) ? to_q24(res_q[set_q], mode_i) : div_quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      pass_q  <= 1'b0;
      set_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) cnt_q <= cnt_q + 1'b1;
      if (pop && item_i.last) begin
        pass_q <= 1'b0;
        idx_q  <= '0;
      end
      if (state_q == S_RD && idx_q == cnt_q) set_q <= 1'b0;
      if (state_q == S_M4 || state_q == S_K4) idx_q <= idx_q + 1'b1;
      if (k_done) begin
        set_q <= ~set_q;
        if (set_q) begin
          pass_q <= 1'b1;
          idx_q  <= '0;
        end
      end
      if (r_done) set_q <= ~set_q;
      if (state_q == S_OUT && out_ready_i) cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cnt_q[drf_pkg::AddrW-1:0]] <= item_i.point;
    rd_q   <= mem[idx_q[drf_pkg::AddrW-1:0]];
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        norm_q[i] <= '0;
        num_q[i]  <= '0;
        den_q[i]  <= '0;
        res_q[i]  <= '0;
        oc_q[i]   <= '0;
        k_q[i]    <= '0;
        r_q[i]    <= '0;
      end
    end else begin
      if (pop && item_i.last) begin
        for (int i = 0; i < 2; i++) begin
          norm_q[i] <= '0;
          num_q[i]  <= '0;
          den_q[i]  <= '0;
          res_q[i]  <= '0;
          oc_q[i]   <= '0;
        end
      end
      if (state_q == S_M2) norm_q[s] <= drf_pkg::sat_add(norm_q[s], prod_q);
      if (state_q == S_M3) num_q[s]  <= drf_pkg::sat_add(num_q[s], prod_q);
      if (state_q == S_M4) den_q[s]  <= drf_pkg::sat_add(den_q[s], prod_q);
      if (state_q == S_K4) begin
        res_q[s] <= drf_pkg::sat_add(res_q[s], term);
        if (outl_q && oc_q[s] != '1) oc_q[s] <= oc_q[s] + 1'b1;
      end
      if (k_done) k_q[set_q] <= k_val;
      if (r_done) r_q[set_q] <= r_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LD) pt_q <= rd_q;
    if (state_q == S_SQO && sq_done) fo_q <= sq_root;
    if (state_q == S_SQC && sq_done) begin
      fc_q <= sq_root;
      if (mode_i == drf_pkg::ModeLs) begin
        p_q <= QuoW'(pt_q.observed);
        q_q <= QuoW'(pt_q.calculated);
      end else if (mode_i == drf_pkg::ModeCr) begin
        p_q <= QuoW'(fo_q);
        q_q <= QuoW'(sq_root);
      end
    end
    if (state_q == S_DVP && div_done) p_q <= div_quo;
    if (state_q == S_DVQ && div_done) q_q <= div_quo;
    if (state_q == S_K2) dev_q <= (p_ext > kq) ? p_ext - kq : kq - p_ext;
    if (state_q == S_K3) outl_q <= outl_d;
  end

  drf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_val),
    .busy_o  (sq_busy),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  drf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .fb24_i  (div_fb24),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign r_off_o  = r_q[0];
  assign r_mer_o  = r_q[1];
  assign oc_off_o = oc_q[0];
  assign oc_mer_o = oc_q[1];

  `DRF_ASSERT(a_cnt_max, cnt_q <= CntW'(drf_pkg::MaxPoints))
  `DRF_ASSERT(a_div_free, div_start |-> !div_busy)
  `DRF_ASSERT(a_sqrt_free, sq_start |-> !sq_busy)
  `DRF_ASSERT_NEXT(a_out_clears, state_q == S_OUT && out_ready_i, cnt_q == '0 && item_ready_o)

endmodule

/* rtl/diffraction_r_factor_top.sv */
// ----------------------------------------------------------------------------
// Normalized R-factor engine, top level
// Stream in diffraction points, get both R-factors and outlier counts.
// ----------------------------------------------------------------------------
// Points are stored at one beat per cycle while the engine is idle (up to
// 4096; a point with zero intensity error is not stored). A beat with tlast
// runs two passes over the stored points through one shared square-root unit
// and one bit-serial divider, with two divides per point in the weighted
// forms and none in the plain forms, and up to four more divides close the
// job. Intake continues into a two-beat queue while the passes run and while
// the result waits on the master side.
module diffraction_r_factor_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [drf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [drf_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // observed, calculated, intensity_error, amplitude_error (24 bits each)
  input  logic [drf_pkg::InDataW-1:0]    s_axis_tdata,
  // meridional
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // r_factor, meridional_r_factor (32 each), outlier_count,
  // meridional_outlier_count (13 each), zero fill
  output logic [drf_pkg::OutDataW-1:0]   m_axis_tdata
);

  drf_pkg::drf_mode_e           mode_q;
  logic [drf_pkg::LimW-1:0]     limit_q;
  logic                         item_valid, item_ready;
  drf_pkg::drf_item_t           item;
  logic [drf_pkg::QuoW-1:0]     r_off, r_mer;
  logic [drf_pkg::OcW-1:0]      oc_off, oc_mer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= drf_pkg::ModeWls;
      limit_q <= drf_pkg::LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        drf_pkg::CfgIdxMode:  mode_q  <= drf_pkg::drf_mode_e'(cfg_data_i[1:0]);
        drf_pkg::CfgIdxLimit: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  drf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  drf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .limit_i      (limit_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .r_off_o      (r_off),
    .r_mer_o      (r_mer),
    .oc_off_o     (oc_off),
    .oc_mer_o     (oc_mer)
  );

  assign m_axis_tdata = {6'd0, oc_mer, oc_off, r_mer, r_off};

endmodule
